>>> hdl/cau_pkg.sv
// shared types and codes of the complex arithmetic unit
// holds op, state and status codes plus the product schedule table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    localparam int WORD_WIDTH   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_EXPONENT = 15;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_POW  = 3'd4,
        OP_MAG  = 3'd5,
        OP_CONJ = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_SAT     = 2'd1,
        STAT_DIVZERO = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_POST,
        ST_DIV,
        ST_SQRT,
        ST_FIN
    } t_state;

    typedef enum logic [2:0] {
        OPND_AR,
        OPND_AI,
        OPND_BR,
        OPND_BI,
        OPND_PR,
        OPND_PI
    } t_opnd;

    typedef enum logic [1:0] {
        DST_RE,
        DST_IM,
        DST_DEN
    } t_dest;

    typedef struct packed {
        t_opnd xs;
        t_opnd ys;
        t_dest dst;
        logic  sub;
    } t_mac_step;

    // number of partial products an op runs through the multiplier
    function automatic logic [2:0] mac_len(input t_op op);
        logic [2:0] n;
        case (op)
            OP_MUL:  n = 3'd4;
            OP_DIV:  n = 3'd6;
            OP_POW:  n = 3'd4;
            OP_MAG:  n = 3'd2;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic t_mac_step mac_step(input t_op op, input logic [2:0] idx);
        t_mac_step s;
        s = '{xs: OPND_AR, ys: OPND_AR, dst: DST_RE, sub: 1'b0};
        case (op)
            OP_MUL: begin
                case (idx)
                    3'd0:    s = '{xs: OPND_AR, ys: OPND_BR, dst: DST_RE, sub: 1'b0};
                    3'd1:    s = '{xs: OPND_AI, ys: OPND_BI, dst: DST_RE, sub: 1'b1};
                    3'd2:    s = '{xs: OPND_AR, ys: OPND_BI, dst: DST_IM, sub: 1'b0};
                    default: s = '{xs: OPND_AI, ys: OPND_BR, dst: DST_IM, sub: 1'b0};
                endcase
            end
            OP_DIV: begin
                case (idx)
                    3'd0:    s = '{xs: OPND_AR, ys: OPND_BR, dst: DST_RE, sub: 1'b0};
                    3'd1:    s = '{xs: OPND_AI, ys: OPND_BI, dst: DST_RE, sub: 1'b0};
                    3'd2:    s = '{xs: OPND_AI, ys: OPND_BR, dst: DST_IM, sub: 1'b0};
                    3'd3:    s = '{xs: OPND_AR, ys: OPND_BI, dst: DST_IM, sub: 1'b1};
                    3'd4:    s = '{xs: OPND_BR, ys: OPND_BR, dst: DST_DEN, sub: 1'b0};
                    default: s = '{xs: OPND_BI, ys: OPND_BI, dst: DST_DEN, sub: 1'b0};
                endcase
            end
            OP_POW: begin
                case (idx)
                    3'd0:    s = '{xs: OPND_PR, ys: OPND_AR, dst: DST_RE, sub: 1'b0};
                    3'd1:    s = '{xs: OPND_PI, ys: OPND_AI, dst: DST_RE, sub: 1'b1};
                    3'd2:    s = '{xs: OPND_PR, ys: OPND_AI, dst: DST_IM, sub: 1'b0};
                    default: s = '{xs: OPND_PI, ys: OPND_AR, dst: DST_IM, sub: 1'b0};
                endcase
            end
            OP_MAG: begin
                case (idx)
                    3'd0:    s = '{xs: OPND_AR, ys: OPND_AR, dst: DST_RE, sub: 1'b0};
                    default: s = '{xs: OPND_AI, ys: OPND_AI, dst: DST_RE, sub: 1'b0};
                endcase
            end
            default: s = '{xs: OPND_AR, ys: OPND_AR, dst: DST_RE, sub: 1'b0};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hdl/cau_mul.sv
// shared signed multiplier of the complex arithmetic unit, product registered
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module cau_mul #(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                          i_clk,
    input  wire logic signed [WORD_WIDTH-1:0]  i_x,
    input  wire logic signed [WORD_WIDTH-1:0]  i_y,
    output logic signed [2*WORD_WIDTH-1:0]     o_p
);

    logic signed [2*WORD_WIDTH-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_x * i_y;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

>>> hdl/complex_arithmetic_unit.sv
// sequence from the input transfer to output valid: add, sub and conjugate go straight to the final state;
// multiply runs its products through the multiplier; power one multiply per exponent step; magnitude
// the squares then (WORD_WIDTH+1) square root steps; divide (Q16.16 by default), one quotient bit a cycle
// per part; a stalled output register holds the unit in its final state
// one item at a time; the next transfer is taken once the result sits in the output register
// reset is synchronous, active low, and clears the sequencer and the output valid
`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit #(
    parameter int WORD_WIDTH   = cau_pkg::WORD_WIDTH,
    parameter int FRAC_BITS    = cau_pkg::FRAC_BITS,
    parameter int MAX_EXPONENT = cau_pkg::MAX_EXPONENT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [2:0]                   i_op,
    input  wire logic signed [WORD_WIDTH-1:0] i_a_real,
    input  wire logic signed [WORD_WIDTH-1:0] i_a_imag,
    input  wire logic signed [WORD_WIDTH-1:0] i_b_real,
    input  wire logic signed [WORD_WIDTH-1:0] i_b_imag,
    input  wire logic [3:0]                   i_exponent,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [WORD_WIDTH-1:0]      o_res_real,
    output logic signed [WORD_WIDTH-1:0]      o_res_imag,
    output logic [1:0]                        o_status
);

    localparam int W  = WORD_WIDTH;
    localparam int AW = 2 * W + 2;
    localparam int NW = AW + FRAC_BITS;
    localparam int RW = W + 4;
    localparam int CW = $clog2(NW + 1);

    localparam logic signed [AW-1:0] SMAX = {{(AW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [AW-1:0] SMIN = {{(AW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [AW-1:0] ONE_A = {{(AW-1){1'b0}}, 1'b1} << FRAC_BITS;

    function automatic logic signed [AW-1:0] f_sx(input logic [W-1:0] v);
        return {{(AW-W){v[W-1]}}, v};
    endfunction

    // flag in the top bit, clamped word below
    function automatic logic [W:0] f_sat(input logic signed [AW-1:0] v);
        logic [W:0] r;
        if (v > SMAX) begin
            r = {1'b1, SMAX[W-1:0]};
        end else if (v < SMIN) begin
            r = {1'b1, SMIN[W-1:0]};
        end else begin
            r = {1'b0, v[W-1:0]};
        end
        return r;
    endfunction

    // signed clamp of a quotient magnitude
    function automatic logic [W:0] f_qsat(input logic [NW-1:0] q, input logic neg);
        logic [W:0]   r;
        logic         hi_nz;
        logic         is_min;
        logic [W-1:0] lo;
        hi_nz  = |q[NW-1:W-1];
        is_min = q[W-1] && (q[NW-1:W] == '0) && (q[W-2:0] == '0);
        lo     = q[W-1:0];
        if (!neg) begin
            r = hi_nz ? {1'b1, SMAX[W-1:0]} : {1'b0, lo};
        end else if (hi_nz && !is_min) begin
            r = {1'b1, SMIN[W-1:0]};
        end else begin
            r = {1'b0, W'(-lo)};
        end
        return r;
    endfunction

    cau_pkg::t_state    r_state, n_state;
    logic [2:0]         r_op, n_op;
    logic [W-1:0]       r_ar, n_ar, r_ai, n_ai, r_br, n_br, r_bi, n_bi;
    logic [W-1:0]       r_pr, n_pr, r_pi, n_pi;
    logic [3:0]         r_exp, n_exp, r_pw, n_pw;
    logic signed [AW-1:0] r_acc_re, n_acc_re, r_acc_im, n_acc_im, r_acc_den, n_acc_den;
    logic [2:0]         r_k, n_k;
    logic               r_flag, n_flag, r_dz, n_dz;
    logic [W-1:0]       r_res_re, n_res_re, r_res_im, n_res_im;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [NW-1:0]      r_num, n_num, r_quo, n_quo;
    logic [AW-1:0]      r_rem, n_rem;
    logic               r_neg, n_neg, r_part, n_part;
    logic               r_ovalid, n_ovalid;
    logic [W-1:0]       r_ore, n_ore, r_oim, n_oim;
    logic [1:0]         r_ost, n_ost;

    logic [3:0]              e_cl;
    logic [W:0]              one_s, s_re, s_im;
    cau_pkg::t_mac_step      issue, accum;
    logic [2:0]              len;
    logic signed [W-1:0]     mul_x, mul_y;
    logic signed [2*W-1:0]   prod;
    logic signed [AW-1:0]    prod_x;
    logic [AW-1:0]           amag;
    logic [AW:0]             drem2, ddiff;
    logic                    dge;
    logic [NW-1:0]           qfull;
    logic [W:0]              qs;
    logic [RW-1:0]           srem2, strial;
    logic                    sge;
    logic [W:0]              root;

    function automatic logic [W-1:0] f_opnd(input cau_pkg::t_opnd s, input logic [W-1:0] ar,
                                            input logic [W-1:0] ai, input logic [W-1:0] br,
                                            input logic [W-1:0] bi, input logic [W-1:0] pr,
                                            input logic [W-1:0] pi);
        logic [W-1:0] v;
        case (s)
            cau_pkg::OPND_AR: v = ar;
            cau_pkg::OPND_AI: v = ai;
            cau_pkg::OPND_BR: v = br;
            cau_pkg::OPND_BI: v = bi;
            cau_pkg::OPND_PR: v = pr;
            default:          v = pi;
        endcase
        return v;
    endfunction

    assign e_cl  = (32'(i_exponent) > MAX_EXPONENT) ? 4'(MAX_EXPONENT) : i_exponent;
    assign one_s = f_sat(ONE_A);
    assign len   = cau_pkg::mac_len(cau_pkg::t_op'(r_op));
    assign issue = cau_pkg::mac_step(cau_pkg::t_op'(r_op), r_k);
    assign accum = cau_pkg::mac_step(cau_pkg::t_op'(r_op), r_k - 3'd1);
    assign mul_x = f_opnd(issue.xs, r_ar, r_ai, r_br, r_bi, r_pr, r_pi);
    assign mul_y = f_opnd(issue.ys, r_ar, r_ai, r_br, r_bi, r_pr, r_pi);

    cau_mul #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_mul (
        .i_clk(i_clk),
        .i_x  (mul_x),
        .i_y  (mul_y),
        .o_p  (prod)
    );

    assign prod_x = {{2{prod[2*W-1]}}, prod};

    // restoring divide step, one quotient bit
    assign drem2 = {r_rem, r_num[NW-1]};
    assign ddiff = drem2 - {1'b0, r_acc_den};
    assign dge   = (drem2 >= {1'b0, r_acc_den});
    assign qfull = {r_quo[NW-2:0], dge};
    assign qs    = f_qsat(qfull, r_neg);

    // square root step, two radicand bits
    assign srem2  = {r_rem[RW-3:0], r_num[NW-1:NW-2]};
    assign strial = {{(RW-W-3){1'b0}}, r_quo[W:0], 2'b01};
    assign sge    = (srem2 >= strial);
    assign root   = {r_quo[W-1:0], sge};

    always_comb begin
        n_state = r_state;   n_op = r_op;
        n_ar = r_ar;  n_ai = r_ai;  n_br = r_br;  n_bi = r_bi;
        n_pr = r_pr;  n_pi = r_pi;  n_exp = r_exp; n_pw = r_pw;
        n_acc_re = r_acc_re; n_acc_im = r_acc_im; n_acc_den = r_acc_den;
        n_k = r_k;  n_flag = r_flag;  n_dz = r_dz;
        n_res_re = r_res_re;  n_res_im = r_res_im;
        n_cnt = r_cnt;  n_num = r_num;  n_quo = r_quo;  n_rem = r_rem;
        n_neg = r_neg;  n_part = r_part;
        n_ovalid = r_ovalid;  n_ore = r_ore;  n_oim = r_oim;  n_ost = r_ost;
        s_re = '0;  s_im = '0;  amag = '0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            cau_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_op;
                    n_ar = i_a_real;  n_ai = i_a_imag;
                    n_br = i_b_real;  n_bi = i_b_imag;
                    n_exp = e_cl;  n_pw = '0;  n_k = '0;
                    n_pr = one_s[W-1:0];  n_pi = '0;
                    n_acc_re = '0;  n_acc_im = '0;  n_acc_den = '0;
                    n_flag = 1'b0;  n_dz = 1'b0;
                    case (cau_pkg::t_op'(i_op))
                        cau_pkg::OP_ADD: begin
                            s_re = f_sat(f_sx(i_a_real) + f_sx(i_b_real));
                            s_im = f_sat(f_sx(i_a_imag) + f_sx(i_b_imag));
                            n_res_re = s_re[W-1:0];  n_res_im = s_im[W-1:0];
                            n_flag = s_re[W] | s_im[W];
                            n_state = cau_pkg::ST_FIN;
                        end
                        cau_pkg::OP_SUB: begin
                            s_re = f_sat(f_sx(i_a_real) - f_sx(i_b_real));
                            s_im = f_sat(f_sx(i_a_imag) - f_sx(i_b_imag));
                            n_res_re = s_re[W-1:0];  n_res_im = s_im[W-1:0];
                            n_flag = s_re[W] | s_im[W];
                            n_state = cau_pkg::ST_FIN;
                        end
                        cau_pkg::OP_MUL, cau_pkg::OP_DIV, cau_pkg::OP_MAG: begin
                            n_state = cau_pkg::ST_MAC;
                        end
                        cau_pkg::OP_POW: begin
                            n_flag = one_s[W];
                            if (e_cl == 4'd0) begin
                                n_res_re = one_s[W-1:0];  n_res_im = '0;
                                n_state = cau_pkg::ST_FIN;
                            end else begin
                                n_state = cau_pkg::ST_MAC;
                            end
                        end
                        cau_pkg::OP_CONJ: begin
                            s_im = f_sat(-f_sx(i_a_imag));
                            n_res_re = i_a_real;  n_res_im = s_im[W-1:0];
                            n_flag = s_im[W];
                            n_state = cau_pkg::ST_FIN;
                        end
                        default: begin
                            n_res_re = '0;  n_res_im = '0;
                            n_state = cau_pkg::ST_FIN;
                        end
                    endcase
                end
            end
            cau_pkg::ST_MAC: begin
                // product of the previous issue lands now
                if (r_k != 3'd0) begin
                    case (accum.dst)
                        cau_pkg::DST_RE:
                            n_acc_re = accum.sub ? r_acc_re - prod_x : r_acc_re + prod_x;
                        cau_pkg::DST_IM:
                            n_acc_im = accum.sub ? r_acc_im - prod_x : r_acc_im + prod_x;
                        default:
                            n_acc_den = r_acc_den + prod_x;
                    endcase
                end
                n_k = r_k + 3'd1;
                if (r_k == len) begin
                    n_state = cau_pkg::ST_POST;
                end
            end
            cau_pkg::ST_POST: begin
                n_rem = '0;  n_quo = '0;  n_cnt = '0;  n_part = 1'b0;
                case (cau_pkg::t_op'(r_op))
                    cau_pkg::OP_MUL, cau_pkg::OP_POW: begin
                        s_re = f_sat(r_acc_re >>> FRAC_BITS);
                        s_im = f_sat(r_acc_im >>> FRAC_BITS);
                        n_flag = r_flag | s_re[W] | s_im[W];
                        n_res_re = s_re[W-1:0];  n_res_im = s_im[W-1:0];
                        n_pr = s_re[W-1:0];  n_pi = s_im[W-1:0];
                        n_pw = r_pw + 4'd1;
                        if (cau_pkg::t_op'(r_op) == cau_pkg::OP_POW && (r_pw + 4'd1) != r_exp)
                        begin
                            n_k = '0;  n_acc_re = '0;  n_acc_im = '0;
                            n_state = cau_pkg::ST_MAC;
                        end else begin
                            n_state = cau_pkg::ST_FIN;
                        end
                    end
                    cau_pkg::OP_DIV: begin
                        if (r_acc_den == '0) begin
                            n_dz = 1'b1;  n_res_re = '0;  n_res_im = '0;
                            n_state = cau_pkg::ST_FIN;
                        end else begin
                            n_neg = r_acc_re[AW-1];
                            amag  = r_acc_re[AW-1] ? AW'(-r_acc_re) : AW'(r_acc_re);
                            n_num = {amag, {FRAC_BITS{1'b0}}};
                            n_state = cau_pkg::ST_DIV;
                        end
                    end
                    default: begin
                        n_num = {r_acc_re, {FRAC_BITS{1'b0}}};
                        n_state = cau_pkg::ST_SQRT;
                    end
                endcase
            end
            cau_pkg::ST_DIV: begin
                n_rem = dge ? ddiff[AW-1:0] : drem2[AW-1:0];
                n_quo = qfull;
                n_num = r_num << 1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    n_flag = r_flag | qs[W];
                    n_rem = '0;  n_quo = '0;  n_cnt = '0;
                    if (!r_part) begin
                        // real part done, set up the imaginary part
                        n_res_re = qs[W-1:0];
                        n_part = 1'b1;
                        n_neg = r_acc_im[AW-1];
                        amag  = r_acc_im[AW-1] ? AW'(-r_acc_im) : AW'(r_acc_im);
                        n_num = {amag, {FRAC_BITS{1'b0}}};
                    end else begin
                        n_res_im = qs[W-1:0];
                        n_state = cau_pkg::ST_FIN;
                    end
                end
            end
            cau_pkg::ST_SQRT: begin
                n_rem = AW'(sge ? srem2 - strial : srem2);
                n_quo = NW'(root);
                n_num = r_num << 2;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(W)) begin
                    if (root[W] || root[W-1]) begin
                        n_res_re = SMAX[W-1:0];
                        n_flag = 1'b1;
                    end else begin
                        n_res_re = root[W-1:0];
                    end
                    n_res_im = '0;
                    n_state = cau_pkg::ST_FIN;
                end
            end
            cau_pkg::ST_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_ore = r_res_re;
                    n_oim = r_res_im;
                    n_ost = r_dz ? cau_pkg::STAT_DIVZERO :
                            (r_flag ? cau_pkg::STAT_SAT : cau_pkg::STAT_OK);
                    n_state = cau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cau_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= cau_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;  r_ar <= n_ar;  r_ai <= n_ai;  r_br <= n_br;  r_bi <= n_bi;
        r_pr <= n_pr;  r_pi <= n_pi;  r_exp <= n_exp;  r_pw <= n_pw;
        r_acc_re <= n_acc_re;  r_acc_im <= n_acc_im;  r_acc_den <= n_acc_den;
        r_k <= n_k;  r_flag <= n_flag;  r_dz <= n_dz;
        r_res_re <= n_res_re;  r_res_im <= n_res_im;
        r_cnt <= n_cnt;  r_num <= n_num;  r_quo <= n_quo;  r_rem <= n_rem;
        r_neg <= n_neg;  r_part <= n_part;
        r_ore <= n_ore;  r_oim <= n_oim;  r_ost <= n_ost;
    end

    assign o_in_ready  = (r_state == cau_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_res_real  = r_ore;
    assign o_res_imag  = r_oim;
    assign o_status    = r_ost;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready still high after an input transfer");

    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cau_pkg::STAT_DIVZERO) |->
        (o_res_real == '0 && o_res_imag == '0))
        else $error("division by zero with a nonzero result");

    a_mac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cau_pkg::ST_MAC) |-> (r_k <= len))
        else $error("product step counter ran past the schedule");

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cau_pkg::ST_DIV) |-> (r_cnt < CW'(NW)))
        else $error("divide step counter out of range");

endmodule

`default_nettype wire
